// ----- rtl/core/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared types and constants for the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int MaxItems = 1024;
  localparam int SegSlots = 64;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);
  localparam int SlotW    = $clog2(SegSlots);
  localparam int StatW    = 3;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;
  localparam cmd_t CMD_INIT  = 2'd3;

  typedef logic [StatW-1:0] stat_t;
  localparam stat_t ST_OK      = 3'd0;
  localparam stat_t ST_NOSPACE = 3'd1;
  localparam stat_t ST_BADIDX  = 3'd2;
  localparam stat_t ST_FULL    = 3'd3;
  localparam stat_t ST_ZERO    = 3'd4;
  localparam stat_t ST_NOINIT  = 3'd5;

  typedef struct packed {
    logic [IdxW-1:0]  start;
    logic [CntW-1:0]  length;
    logic [SlotW-1:0] rank;
  } seg_t;

endpackage

// ----- rtl/core/first_fit_segment_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// first-fit free-list allocator with coalescing over an item pool
// ----------------------------------------------------------------------------
// One request is handled at a time, and in_ready stays low from acceptance
// until its result has been taken. Allocate and free walk the 64-entry
// segment table one slot per cycle; the table read is registered. An
// allocate goes from acceptance through the scan, a finish step and the
// output step to out_valid. An exact fit removes a segment and adds a
// rank-update pass. A free adds the allocation-length lookup step first,
// and also needs the rank pass for a merge on both sides or a push to the
// front. Initialize clears the 1024-entry allocation-length memory one
// entry per cycle. Query and requests rejected up front go straight to the
// output step, and a free of a bad index goes there after the lookup step.
// A new request can be taken the cycle after the result has been accepted.
module first_fit_segment_allocator_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ffsa_pkg::CntW-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [ffsa_pkg::CntW-1:0] in_item_count,
  input  logic [ffsa_pkg::IdxW-1:0] in_item_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ffsa_pkg::StatW-1:0] out_status,
  output logic [ffsa_pkg::IdxW-1:0] out_start_index,
  output logic [ffsa_pkg::CntW-1:0] out_free_items,
  output logic                     out_nothing_allocated
);

  localparam int SW = ffsa_pkg::SlotW;
  localparam int CW = ffsa_pkg::CntW;
  localparam int IW = ffsa_pkg::IdxW;
  localparam int SegN = ffsa_pkg::SegSlots;
  localparam int ItemN = ffsa_pkg::MaxItems;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CLEAR = 8'b00000010,
    S_ALOOK = 8'b00000100,  // alloc-length memory read
    S_SCAN  = 8'b00001000,
    S_DEC   = 8'b00010000,  // pass: ranks above removed one drop
    S_INC   = 8'b00100000,  // pass: all other ranks rise (push front)
    S_FIN   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // segment table: fields in memory, valid bits in flops
  ffsa_pkg::seg_t seg_mem [SegN];
  logic [SegN-1:0] seg_valid_r;
  logic [CW-1:0] alen_mem [ItemN];
  logic [CW-1:0] alen_rd_r;

  logic [CW-1:0] pool_items_r;
  logic [CW-1:0] free_total_r;
  logic [CW-1:0] live_r;
  logic          ready_r;

  // latched request
  ffsa_pkg::cmd_t  cmd_r;
  logic [CW-1:0]   cnt_r;
  logic [IW-1:0]   idx_r;
  logic [CW-1:0]   n_r;       // length being freed

  // scan bookkeeping
  logic [SW:0]     ptr_r;     // read address, one wider to reach the end
  logic [SW:0]     pd_r;      // slot whose data sits in rd_r, top bit: none
  logic            hit_r, left_v_r, right_v_r, slot_v_r;
  logic [SW-1:0]   hit_slot_r, left_r, right_r, slot_r;
  ffsa_pkg::seg_t  hit_seg_r, left_seg_r, right_seg_r;
  logic [SW-1:0]   drop_rank_r;
  logic [IW:0]     clr_r;

  ffsa_pkg::seg_t  rd_r;      // registered table read
  logic [SW-1:0]   ra;
  logic [SW-1:0]   p;
  logic            pv;
  logic [IW+CW:0]  seg_end;

  // output register
  logic            ov_r;
  ffsa_pkg::stat_t ost_r;
  logic [IW-1:0]   ostart_r;

  assign ra = ptr_r[SW-1:0];
  assign p  = pd_r[SW-1:0];
  assign pv = seg_valid_r[p];
  assign seg_end = (IW+CW+1)'(rd_r.start) + (IW+CW+1)'(rd_r.length);

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_start_index = ostart_r;
  assign out_free_items = free_total_r;
  assign out_nothing_allocated = (live_r == '0);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid && in_ready) begin
                 if (in_command == ffsa_pkg::CMD_INIT) state_nxt = S_CLEAR;
                 else if (!ready_r || in_command == ffsa_pkg::CMD_QUERY) state_nxt = S_OUT;
                 else if (in_command == ffsa_pkg::CMD_ALLOC) begin
                   if (in_item_count == '0 || in_item_count > free_total_r) state_nxt = S_OUT;
                   else state_nxt = S_SCAN;
                 end else state_nxt = S_ALOOK;
               end
      S_CLEAR: if (clr_r == (IW+1)'(ItemN - 1)) state_nxt = S_OUT;
      S_ALOOK: state_nxt = (alen_rd_r == '0) ? S_OUT : S_SCAN;
      S_SCAN:  if (ptr_r[SW] && pd_r[SW]) state_nxt = S_FIN;
      S_DEC:   if (ptr_r[SW] && pd_r[SW]) state_nxt = S_OUT;
      S_INC:   if (ptr_r[SW] && pd_r[SW]) state_nxt = S_OUT;
      S_FIN: begin
        // exact fit and two-sided merge drop a segment, a push shifts all ranks
        if (cmd_r == ffsa_pkg::CMD_ALLOC)
          state_nxt = (hit_r && hit_seg_r.length == cnt_r) ? S_DEC : S_OUT;
        else if (left_v_r && right_v_r) state_nxt = S_DEC;
        else if (!left_v_r && !right_v_r && slot_v_r) state_nxt = S_INC;
        else state_nxt = S_OUT;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory reads, writes and datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) alen_rd_r <= alen_mem[in_item_index];
    rd_r <= seg_mem[ra];
    if (state_r == S_CLEAR) alen_mem[clr_r[IW-1:0]] <= '0;
    if (state_r == S_FIN && cmd_r == ffsa_pkg::CMD_ALLOC && hit_r)
      alen_mem[hit_seg_r.start] <= cnt_r;
    if (state_r == S_FIN && cmd_r == ffsa_pkg::CMD_FREE &&
        (left_v_r || right_v_r || slot_v_r))
      alen_mem[idx_r] <= '0;
    if (state_r == S_DEC && pd_r[SW] == 1'b0 && pv && rd_r.rank > drop_rank_r)
      seg_mem[p].rank <= rd_r.rank - 1'b1;
    if (state_r == S_INC && pd_r[SW] == 1'b0 && pv && p != slot_r)
      seg_mem[p].rank <= rd_r.rank + 1'b1;
    if (state_r == S_CLEAR && clr_r == '0)
      seg_mem[0] <= '{start: '0, length: (pool_items_r == '0) ? CW'(1) :
                      (pool_items_r > CW'(ItemN)) ? CW'(ItemN) : pool_items_r, rank: '0};
    if (state_r == S_FIN) begin
      if (cmd_r == ffsa_pkg::CMD_ALLOC && hit_r && hit_seg_r.length != cnt_r)
        seg_mem[hit_slot_r] <= '{start: hit_seg_r.start + IW'(cnt_r),
                                length: hit_seg_r.length - cnt_r, rank: hit_seg_r.rank};
      if (cmd_r == ffsa_pkg::CMD_FREE) begin
        if (left_v_r)
          seg_mem[left_r].length <= left_seg_r.length + n_r +
                                    (right_v_r ? right_seg_r.length : CW'(0));
        else if (right_v_r)
          seg_mem[right_r] <= '{start: idx_r, length: right_seg_r.length + n_r,
                                rank: right_seg_r.rank};
        else if (slot_v_r)
          seg_mem[slot_r] <= '{start: idx_r, length: n_r, rank: '0};
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seg_valid_r <= '0;
      pool_items_r <= CW'(ItemN);
      free_total_r <= '0;
      live_r <= '0;
      ready_r <= 1'b0;
      ov_r <= 1'b0;
      ptr_r <= '0;
      pd_r <= {1'b1, {SW{1'b0}}};
      clr_r <= '0;
      hit_r <= 1'b0;
      left_v_r <= 1'b0;
      right_v_r <= 1'b0;
      slot_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) pool_items_r <= cfg_wdata;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r <= in_command;
          cnt_r <= in_item_count;
          idx_r <= in_item_index;
          ptr_r <= '0;
          pd_r <= {1'b1, {SW{1'b0}}};
          clr_r <= '0;
          hit_r <= 1'b0;
          left_v_r <= 1'b0;
          right_v_r <= 1'b0;
          slot_v_r <= 1'b0;
          ostart_r <= '0;
          if (in_command == ffsa_pkg::CMD_INIT) ost_r <= ffsa_pkg::ST_OK;
          else if (!ready_r) ost_r <= ffsa_pkg::ST_NOINIT;
          else if (in_command == ffsa_pkg::CMD_ALLOC && in_item_count == '0)
            ost_r <= ffsa_pkg::ST_ZERO;
          else if (in_command == ffsa_pkg::CMD_ALLOC && in_item_count > free_total_r)
            ost_r <= ffsa_pkg::ST_NOSPACE;
          else ost_r <= ffsa_pkg::ST_OK;
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '0) begin
            seg_valid_r <= {{(SegN-1){1'b0}}, 1'b1};
            free_total_r <= (pool_items_r == '0) ? CW'(1) :
                            (pool_items_r > CW'(ItemN)) ? CW'(ItemN) : pool_items_r;
            live_r <= '0;
            ready_r <= 1'b1;
          end
        end
        S_ALOOK: begin
          n_r <= alen_rd_r;
          if (alen_rd_r == '0) ost_r <= ffsa_pkg::ST_BADIDX;
        end
        S_SCAN: begin
          if (!ptr_r[SW]) ptr_r <= ptr_r + 1'b1;
          pd_r <= ptr_r;
          if (!pd_r[SW]) begin
            if (cmd_r == ffsa_pkg::CMD_ALLOC) begin
              if (pv && rd_r.length >= cnt_r && (!hit_r || rd_r.rank < hit_seg_r.rank)) begin
                hit_r <= 1'b1;
                hit_slot_r <= p;
                hit_seg_r <= rd_r;
              end
            end else begin
              if (!pv) begin
                if (!slot_v_r) begin
                  slot_v_r <= 1'b1;
                  slot_r <= p;
                end
              end else begin
                if (seg_end == (IW+CW+1)'(idx_r)) begin
                  left_v_r <= 1'b1;
                  left_r <= p;
                  left_seg_r <= rd_r;
                end
                if ((IW+CW+1)'(rd_r.start) == (IW+CW+1)'(idx_r) + (IW+CW+1)'(n_r)) begin
                  right_v_r <= 1'b1;
                  right_r <= p;
                  right_seg_r <= rd_r;
                end
              end
            end
          end
        end
        S_FIN: begin
          ptr_r <= '0;
          pd_r <= {1'b1, {SW{1'b0}}};
          if (cmd_r == ffsa_pkg::CMD_ALLOC) begin
            if (!hit_r) ost_r <= ffsa_pkg::ST_NOSPACE;
            else begin
              ostart_r <= hit_seg_r.start;
              live_r <= live_r + 1'b1;
              free_total_r <= free_total_r - cnt_r;
              if (hit_seg_r.length == cnt_r) begin
                seg_valid_r[hit_slot_r] <= 1'b0;
                drop_rank_r <= hit_seg_r.rank;
              end
            end
          end else if (!left_v_r && !right_v_r && !slot_v_r) begin
            ost_r <= ffsa_pkg::ST_FULL;
          end else begin
            if (live_r != '0) live_r <= live_r - 1'b1;
            free_total_r <= free_total_r + n_r;
            if (left_v_r && right_v_r) begin
              seg_valid_r[right_r] <= 1'b0;
              drop_rank_r <= right_seg_r.rank;
            end else if (!left_v_r && !right_v_r) begin
              seg_valid_r[slot_r] <= 1'b1;
            end
          end
        end
        S_DEC, S_INC: begin
          if (!ptr_r[SW]) ptr_r <= ptr_r + 1'b1;
          pd_r <= ptr_r;
        end
        S_OUT: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // no new request while a result is held
  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> !in_ready)
    else $error("request accepted over a pending result");
  // free count never exceeds the 1024-item maximum pool
  assert property (@(posedge clk) disable iff (!rst_n) free_total_r <= CW'(ItemN))
    else $error("free count out of range");
  // a result is raised only after the sequencer's output step
  assert property (@(posedge clk) disable iff (!rst_n) $rose(ov_r) |-> $past(state_r == S_OUT))
    else $error("result without output step");

endmodule
